[hdl/mfc_pkg.sv]
// package for the motion frame conditioner: types, constants and tables
package mfc_pkg;

  localparam int unsigned NumRegs   = 7;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned AtanLen   = 24;
  localparam int unsigned CordW     = 30;
  localparam int unsigned AngW      = 28;
  // output angles are in 1/16 degree
  localparam int unsigned AngFracBits = 4;

  localparam logic [2:0] RegWeight    = 3'd0;
  localparam logic [2:0] RegThreshold = 3'd1;
  localparam logic [2:0] RegGravity   = 3'd2;
  localparam logic [2:0] RegCooldown  = 3'd3;
  localparam logic [2:0] RegDistLimit = 3'd4;
  localparam logic [2:0] RegMotionEn  = 3'd5;
  localparam logic [2:0] RegTempEn    = 3'd6;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StSqrtYz,
    StSqrtMag,
    StRollInit,
    StRollIter,
    StPitchInit,
    StPitchIter,
    StDist,
    StEma,
    StDone
  } seq_state_e;

  typedef struct packed {
    logic [8:0]  weight;
    logic [15:0] threshold;
    logic [15:0] gravity;
    logic [15:0] cooldown;
    logic [12:0] dist_limit;
    logic        motion_en;
    logic        temp_en;
  } cfg_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [22:0] atan_lut(input logic [4:0] idx);
    logic [22:0] v;
    case (idx)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117306;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

[hdl/motion_frame_conditioner_top.sv]
// motion frame conditioner top: registers, sequencer, shared ema and results
//
//  channel   signals                       direction
//  frame in  in_valid_i / in_ready_o       input  transaction, one sensor frame
//  result    out_valid_o / out_ready_i     output transaction, one conditioned frame
//  config    psel/penable/pwrite/paddr     apb register write and read
//
// a frame finishes sooner when both operands of an angle are zero, and the sequencer
// returns to idle before it takes the next frame; the square-root unit and the cordic
// unit each run one step per cycle.
// reset clears the roll, pitch and distance smoothing state, temperature state starts at 25 C.
// a result waits in the output register while the next frame is computed; the
// sequencer holds in its last state until that register is free.
module motion_frame_conditioner_top import mfc_pkg::*; #(
  parameter int unsigned CordicSteps   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [15:0]   accel_x_i,
  input  logic signed [15:0]   accel_y_i,
  input  logic signed [15:0]   accel_z_i,
  input  logic [14:0]          echo_width_us_i,
  input  logic signed [12:0]   temp_raw_i,
  input  logic [31:0]          time_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [12:0]   roll_avg_o,
  output logic signed [11:0]   pitch_avg_o,
  output logic [12:0]          distance_avg_o,
  output logic                 hand_present_o,
  output logic signed [12:0]   temp_avg_o,
  output logic                 shake_o
);

  localparam int unsigned Shift = 16 - AngFracBits;

  cfg_t cfg_q;
  logic [2:0] reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{weight: 9'd77, threshold: 16'd3341, gravity: 16'd4097,
                 cooldown: 16'd350, dist_limit: 13'd960, motion_en: 1'b1,
                 temp_en: 1'b1};
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegWeight:    cfg_q.weight     <= pwdata[8:0];
        RegThreshold: cfg_q.threshold  <= pwdata[15:0];
        RegGravity:   cfg_q.gravity    <= pwdata[15:0];
        RegCooldown:  cfg_q.cooldown   <= pwdata[15:0];
        RegDistLimit: cfg_q.dist_limit <= pwdata[12:0];
        RegMotionEn:  cfg_q.motion_en  <= pwdata[0];
        RegTempEn:    cfg_q.temp_en    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegWeight:    prdata = {23'd0, cfg_q.weight};
      RegThreshold: prdata = {16'd0, cfg_q.threshold};
      RegGravity:   prdata = {16'd0, cfg_q.gravity};
      RegCooldown:  prdata = {16'd0, cfg_q.cooldown};
      RegDistLimit: prdata = {19'd0, cfg_q.dist_limit};
      RegMotionEn:  prdata = {31'd0, cfg_q.motion_en};
      RegTempEn:    prdata = {31'd0, cfg_q.temp_en};
      default:      prdata = 32'd0;
    endcase
  end

  // frame capture
  logic signed [15:0] ax_q, ay_q, az_q;
  logic [14:0]        echo_q;
  logic signed [12:0] temp_in_q;
  logic [31:0]        now_q;
  logic [33:0]        yz_q;
  logic [33:0]        ax2_q;
  logic [16:0]        r_q, mag_q;

  // state
  logic signed [12:0] roll_s_q, temp_s_q;
  logic signed [11:0] pitch_s_q;
  logic [12:0]        dist_s_q;
  logic               dist_v_q;
  logic [31:0]        last_shake_q;
  logic               shake_q;
  logic signed [12:0] roll_smp_q;
  logic signed [11:0] pitch_smp_q;
  logic [12:0]        d_q;
  logic [1:0]         ema_sel_q;

  // output register
  logic signed [12:0] res_roll_q, res_temp_q;
  logic signed [11:0] res_pitch_q;
  logic [12:0]        res_dist_q;
  logic               res_hand_q, res_shake_q;

  seq_state_e state_q, state_d;
  logic       out_valid_q;
  logic       out_free;
  logic       accept;
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign out_free   = !out_valid_q || out_ready_i;

  // square root unit
  logic        sq_start, sq_done;
  logic [33:0] sq_in;
  logic [16:0] sq_root;
  mfc_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .radicand_i(sq_in),
    .done_o(sq_done), .root_o(sq_root)
  );

  // cordic unit
  logic               co_start, co_done;
  logic signed [17:0] co_y, co_x;
  logic signed [AngW-1:0] co_ang;
  mfc_cordic #(.Steps(CordicSteps)) u_cordic (
    .clk_i, .rst_ni, .start_i(co_start), .y_i(co_y), .x_i(co_x),
    .done_o(co_done), .angle_o(co_ang)
  );

  // angle rounding and clamp
  logic signed [AngW:0] ang_rnd;
  logic signed [AngW:0] lim180, lim90;
  assign ang_rnd = ($signed({co_ang[AngW-1], co_ang}) +
                    (AngW+1)'(1 << (Shift - 1))) >>> Shift;
  assign lim180  = (AngW+1)'(180 << AngFracBits);
  assign lim90   = (AngW+1)'(90 << AngFracBits);

  // shared ema: prev + floor((w*(s-prev)+128)/256) saturated
  logic signed [14:0] ema_prev, ema_smp;
  logic signed [15:0] ema_diff;
  logic signed [26:0] ema_prod;
  logic signed [26:0] ema_sum;
  logic signed [15:0] ema_lo, ema_hi;
  always_comb begin
    case (ema_sel_q)
      2'd0: begin
        ema_prev = 15'(roll_s_q); ema_smp = 15'(roll_smp_q);
        ema_lo = -16'sd4096; ema_hi = 16'sd4095;
      end
      2'd1: begin
        ema_prev = 15'(pitch_s_q); ema_smp = 15'(pitch_smp_q);
        ema_lo = -16'sd2048; ema_hi = 16'sd2047;
      end
      2'd2: begin
        ema_prev = $signed({2'b00, dist_s_q}); ema_smp = $signed({2'b00, d_q});
        ema_lo = 16'sd0; ema_hi = 16'sd8191;
      end
      default: begin
        ema_prev = 15'(temp_s_q); ema_smp = 15'(temp_in_q);
        ema_lo = -16'sd4096; ema_hi = 16'sd4095;
      end
    endcase
    ema_diff = 16'(ema_smp) - 16'(ema_prev);
    ema_prod = 27'($signed({1'b0, cfg_q.weight})) * 27'(ema_diff);
    ema_sum  = 27'(ema_prev) + ((ema_prod + 27'sd128) >>> 8);
  end
  logic signed [15:0] ema_out;
  assign ema_out = (ema_sum < 27'(ema_lo)) ? ema_lo :
                   (ema_sum > 27'(ema_hi)) ? ema_hi : 16'(ema_sum);

  // distance: floor((16*echo+29)/58) via reciprocal and correction
  logic [19:0] dnum;
  logic [39:0] dprod;
  logic [13:0] dq0;
  logic [19:0] drem;
  logic [13:0] dist_calc;
  assign dnum      = {1'b0, echo_q, 4'd0} + 20'd29;
  assign dprod     = 40'(dnum) * 40'd18078;   // floor(2^20/58), low by at most one
  assign dq0       = dprod[33:20];
  assign drem      = dnum - 20'(dq0) * 20'd58;
  assign dist_calc = (drem >= 20'd58) ? dq0 + 14'd1 : dq0;

  // sequencer next state
  logic [1:0] ema_cnt_q;
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:      if (accept) state_d = StSqrtYz;
      StSqrtYz:    if (sq_done) state_d = StSqrtMag;
      StSqrtMag:   if (sq_done) state_d = StRollInit;
      StRollInit:  state_d = StRollIter;
      StRollIter:  if (co_done) state_d = StPitchInit;
      StPitchInit: state_d = StPitchIter;
      StPitchIter: if (co_done) state_d = StDist;
      StDist:      state_d = StEma;
      StEma:       if (ema_cnt_q == 2'd3) state_d = StDone;
      StDone:      if (out_free) state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sq_start = 1'b0;
    sq_in    = yz_q;
    co_start = 1'b0;
    co_y     = 18'(ay_q);
    co_x     = 18'(az_q);
    case (state_q)
      StIdle: begin
        sq_start = accept;
        sq_in    = 34'(33'($signed(accel_y_i) * $signed(accel_y_i))) +
                   34'(33'($signed(accel_z_i) * $signed(accel_z_i)));
      end
      StSqrtYz: begin
        sq_start = sq_done;
        sq_in    = yz_q + ax2_q;
      end
      StRollInit: co_start = 1'b1;
      StPitchInit: begin
        co_start = 1'b1;
        co_y     = -18'(ax_q);
        co_x     = 18'($signed({1'b0, r_q}));
      end
      default: ;
    endcase
  end

  logic [31:0] elapsed;
  logic [17:0] dev;
  assign elapsed = now_q - last_shake_q;
  assign dev = (mag_q >= {1'b0, cfg_q.gravity}) ? 18'(mag_q) - 18'(cfg_q.gravity) :
               18'(cfg_q.gravity) - 18'(mag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      roll_s_q     <= '0;
      pitch_s_q    <= '0;
      dist_s_q     <= '0;
      dist_v_q     <= 1'b0;
      temp_s_q     <= 13'sd400;
      last_shake_q <= '0;
      shake_q      <= 1'b0;
      ema_cnt_q    <= '0;
      ema_sel_q    <= '0;
      r_q          <= '0;
      mag_q        <= '0;
      roll_smp_q   <= '0;
      pitch_smp_q  <= '0;
      d_q          <= '0;
      res_roll_q   <= '0;
      res_pitch_q  <= '0;
      res_dist_q   <= '0;
      res_hand_q   <= 1'b0;
      res_temp_q   <= '0;
      res_shake_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
        res_roll_q  <= roll_s_q;
        res_pitch_q <= pitch_s_q;
        res_dist_q  <= dist_s_q;
        res_hand_q  <= dist_v_q;
        res_temp_q  <= temp_s_q;
        res_shake_q <= shake_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StSqrtYz: if (sq_done) r_q <= sq_root;
        StSqrtMag: if (sq_done) mag_q <= sq_root;
        StRollIter: if (co_done) begin
          roll_smp_q <= (ang_rnd > lim180) ? 13'(lim180) :
                        (ang_rnd < -lim180) ? -13'(lim180) : 13'(ang_rnd);
        end
        StPitchIter: if (co_done) begin
          pitch_smp_q <= (ang_rnd > lim90) ? 12'(lim90) :
                         (ang_rnd < -lim90) ? -12'(lim90) : 12'(ang_rnd);
        end
        StDist: begin
          d_q       <= dist_calc[12:0];
          ema_cnt_q <= 2'd0;
          ema_sel_q <= 2'd0;
          shake_q   <= 1'b0;
          if (cfg_q.motion_en && (dev > 18'(cfg_q.threshold)) &&
              (elapsed > 32'(cfg_q.cooldown))) begin
            shake_q      <= 1'b1;
            last_shake_q <= now_q;
          end
        end
        StEma: begin
          ema_cnt_q <= ema_cnt_q + 2'd1;
          ema_sel_q <= ema_sel_q + 2'd1;
          case (ema_sel_q)
            2'd0: if (cfg_q.motion_en) roll_s_q <= 13'(ema_out);
            2'd1: if (cfg_q.motion_en) pitch_s_q <= 12'(ema_out);
            2'd2: begin
              if (echo_q == 15'd0 || {1'b0, d_q} > {1'b0, cfg_q.dist_limit} ||
                  dist_calc[13]) begin
                dist_s_q <= '0;
                dist_v_q <= 1'b0;
              end else if (!dist_v_q) begin
                dist_s_q <= d_q;
                dist_v_q <= 1'b1;
              end else begin
                dist_s_q <= 13'(ema_out);
              end
            end
            default: if (cfg_q.temp_en) temp_s_q <= 13'(ema_out);
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q      <= accel_x_i;
      ay_q      <= accel_y_i;
      az_q      <= accel_z_i;
      echo_q    <= echo_width_us_i;
      temp_in_q <= temp_raw_i;
      now_q     <= time_ms_i;
      yz_q      <= 34'(33'(accel_y_i * accel_y_i)) + 34'(33'(accel_z_i * accel_z_i));
      ax2_q     <= 34'(33'(accel_x_i * accel_x_i));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign roll_avg_o     = res_roll_q;
  assign pitch_avg_o    = res_pitch_q;
  assign distance_avg_o = res_dist_q;
  assign hand_present_o = res_hand_q;
  assign temp_avg_o     = res_temp_q;
  assign shake_o        = res_shake_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("frame taken while busy");
  a_valid_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> out_valid_o) else $error("result not presented");
  a_hand_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hand_present_o |-> (distance_avg_o == 13'd0)) else $error("distance without hand");

endmodule

[hdl/mfc_isqrt.sv]
// iterative integer square root, one result bit per cycle
module mfc_isqrt import mfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] radicand_i,
  output logic        done_o,
  output logic [16:0] root_o
);

  logic [16:0] root_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [18:0] part_q, part_d;
  logic [18:0] shifted;
  logic [18:0] sub;
  logic [33:0] src_q, src_d;
  logic [16:0] root_n;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      cnt_d  = 5'd17;
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  // restoring: bring down two radicand bits, try subtracting 4*root+1
  always_comb begin
    part_d  = part_q;
    src_d   = src_q;
    shifted = {part_q[16:0], src_q[33:32]};
    sub     = shifted - {root_q, 2'b01};
    if (start_i) begin
      part_d = '0;
      src_d  = radicand_i;
    end else if (busy_q) begin
      src_d = {src_q[31:0], 2'b00};
      if (!sub[18]) begin
        part_d = sub;
      end else begin
        part_d = shifted;
      end
    end
  end

  assign root_n = {root_q[15:0], ~sub[18]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      root_q <= '0;
    end else if (busy_q) begin
      root_q <= root_n;
    end
    part_q <= part_d;
    src_q  <= src_d;
  end

  assign done_o = busy_q && (cnt_q == 5'd1);
  assign root_o = root_n;

endmodule

[hdl/mfc_cordic.sv]
// vectoring cordic, one rotation step per cycle, angle in 2^-16 degree
module mfc_cordic import mfc_pkg::*; #(
  parameter int unsigned Steps = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [17:0] y_i,
  input  logic signed [17:0] x_i,
  output logic               done_o,
  output logic signed [AngW-1:0] angle_o
);

  logic signed [CordW-1:0] x_q, y_q;
  logic signed [AngW-1:0]  z_q;
  logic [4:0]              i_q;
  logic                    busy_q;
  logic signed [CordW-1:0] xs, ys, xn, yn;
  logic signed [AngW-1:0]  a;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign a  = AngW'($signed({1'b0, atan_lut(i_q)}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= (x_i != 0) || (y_i != 0);
      i_q    <= '0;
    end else if (busy_q) begin
      i_q <= i_q + 5'd1;
      if (i_q == 5'(Steps - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i < 0) begin
        z_q <= (y_i >= 0) ? AngW'(180 * 65536) : -AngW'(180 * 65536);
        x_q <= CordW'(-x_i) <<< 8;
        y_q <= CordW'(-y_i) <<< 8;
      end else begin
        z_q <= '0;
        x_q <= CordW'(x_i) <<< 8;
        y_q <= CordW'(y_i) <<< 8;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + a;
      end else if (y_q < 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - a;
      end
    end
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (start_i && x_i == 0 && y_i == 0) ||
                (busy_q && i_q == 5'(Steps - 1));
    end
  end

  assign done_o  = done_q;
  assign angle_o = (x_q == 0 && y_q == 0 && z_q == 0) ? '0 : z_q;

endmodule

[tb/tb_motion_frame_conditioner_top.sv]
// testbench for motion_frame_conditioner_top: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module tb_motion_frame_conditioner_top;
  import mfc_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned ItemsPerPhase = 200;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [14:0]        echo;
    logic signed [12:0] temp;
    logic [31:0]        ms;
  } frame_t;

  typedef struct {
    logic signed [12:0] roll;
    logic signed [11:0] pitch;
    logic [12:0]        distance;
    logic               hand;
    logic signed [12:0] temp;
    logic               shake;
  } result_t;

  typedef struct {
    frame_t  f;
    bit      typed;
    result_t r;
  } dir_row_t;

  typedef struct {
    bit      typed;
    result_t r;
  } note_t;

  // atan(2^-i) in 2^-16 degree
  localparam longint AtanDeg16[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117306, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o;
  logic signed [15:0] accel_x_i, accel_y_i, accel_z_i;
  logic [14:0] echo_width_us_i;
  logic signed [12:0] temp_raw_i;
  logic [31:0] time_ms_i;
  logic out_valid_o, out_ready_i;
  logic signed [12:0] roll_avg_o;
  logic signed [11:0] pitch_avg_o;
  logic [12:0] distance_avg_o;
  logic hand_present_o;
  logic signed [12:0] temp_avg_o;
  logic shake_o;

  motion_frame_conditioner_top DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .accel_x_i, .accel_y_i, .accel_z_i, .echo_width_us_i,
    .temp_raw_i, .time_ms_i, .out_valid_o, .out_ready_i, .roll_avg_o, .pitch_avg_o,
    .distance_avg_o, .hand_present_o, .temp_avg_o, .shake_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor configuration and state
  logic [8:0]  weight_m;
  logic [15:0] threshold_m, gravity_m, cooldown_m;
  logic [12:0] dist_limit_m;
  logic        motion_en_m, temp_en_m;
  longint roll_s, pitch_s, dist_s, temp_s;
  bit     hand_s;
  logic [31:0] last_shake_s;

  result_t expected_results[$];
  note_t   typed_notes[$];
  int      mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit      hold_output = 1'b0;
  logic [31:0] now_ms = 32'd0;

  function automatic longint smooth(longint prev, longint sample, int w);
    longint t, v, lim;
    t = longint'(weight_m) * (sample - prev) + 128;
    v = prev + (t >>> 8);
    lim = longint'(1) << (w - 1);
    if (v < -lim) v = -lim;
    if (v > lim - 1) v = lim - 1;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan2_deg16(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    x *= 256;
    y *= 256;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += AtanDeg16[i];
      end else if (y < 0) begin
        x -= ys; y += xs; z -= AtanDeg16[i];
      end
    end
    return z;
  endfunction

  function automatic longint to_sixteenths(longint z, longint limit_deg);
    longint v;
    v = (z + 2048) >>> 12;
    if (v < -limit_deg * 16) v = -limit_deg * 16;
    if (v > limit_deg * 16) v = limit_deg * 16;
    return v;
  endfunction

  function automatic result_t condition_frame(frame_t f);
    result_t r;
    longint ax, ay, az, rr, mag, dev, d;
    longint unsigned yz;
    ax = longint'(f.ax);
    ay = longint'(f.ay);
    az = longint'(f.az);
    r.shake = 1'b0;
    if (motion_en_m) begin
      yz = longint'(ay * ay + az * az);
      rr = longint'(root_floor(yz));
      mag = longint'(root_floor(yz + longint'(ax * ax)));
      roll_s = smooth(roll_s, to_sixteenths(atan2_deg16(ay, az), 180), 13);
      pitch_s = smooth(pitch_s, to_sixteenths(atan2_deg16(-ax, rr), 90), 12);
      dev = mag - longint'(gravity_m);
      if (dev < 0) dev = -dev;
      if (dev > longint'(threshold_m) && (f.ms - last_shake_s) > {16'd0, cooldown_m}) begin
        r.shake = 1'b1;
        last_shake_s = f.ms;
      end
    end
    d = (16 * longint'(f.echo) + 29) / 58;
    if (f.echo == 0 || d > longint'(dist_limit_m)) begin
      dist_s = 0;
      hand_s = 1'b0;
    end else if (!hand_s) begin
      dist_s = d;
      hand_s = 1'b1;
    end else begin
      dist_s = smooth(dist_s, d, 14);
      if (dist_s < 0) dist_s = 0;
      if (dist_s > 8191) dist_s = 8191;
    end
    if (temp_en_m) temp_s = smooth(temp_s, longint'(f.temp), 13);
    r.roll = roll_s[12:0];
    r.pitch = pitch_s[11:0];
    r.distance = dist_s[12:0];
    r.hand = hand_s;
    r.temp = temp_s[12:0];
    return r;
  endfunction

  // input and output transactions
  always @(posedge clk_i) begin
    frame_t f;
    result_t p, e;
    note_t n;
    cycle_count <= cycle_count + 1;
    if (rst_ni && in_valid_i && in_ready_o) begin
      f = '{accel_x_i, accel_y_i, accel_z_i, echo_width_us_i, temp_raw_i, time_ms_i};
      p = condition_frame(f);
      n = typed_notes.pop_front();
      expected_results.push_back(n.typed ? n.r : p);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result with nothing expected at %0t", $realtime);
      end else begin
        e = expected_results.pop_front();
        if (roll_avg_o !== e.roll || pitch_avg_o !== e.pitch ||
            distance_avg_o !== e.distance || hand_present_o !== e.hand ||
            temp_avg_o !== e.temp || shake_o !== e.shake) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: exp roll %0d pitch %0d dist %0d hand %0b temp %0d shake %0b",
                     $realtime, e.roll, e.pitch, e.distance, e.hand, e.temp, e.shake,
                     " / got roll %0d pitch %0d dist %0d hand %0b temp %0d shake %0b",
                     roll_avg_o, pitch_avg_o, distance_avg_o, hand_present_o, temp_avg_o,
                     shake_o);
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("tb_motion_frame_conditioner_top: errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver side: random stalls, one long hold-off on request
  initial begin
    int n;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_output) begin
        out_ready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_output = 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val, int w);
    logic [31:0] v;
    v = (w < 32) ? ((($urandom() >> w) << w) | val) : val;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrWidth'({idx, 2'b00});
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegWeight:    weight_m = v[8:0];
      RegThreshold: threshold_m = v[15:0];
      RegGravity:   gravity_m = v[15:0];
      RegCooldown:  cooldown_m = v[15:0];
      RegDistLimit: dist_limit_m = v[12:0];
      RegMotionEn:  motion_en_m = v[0];
      RegTempEn:    temp_en_m = v[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_frame(frame_t f, bit typed, result_t r);
    typed_notes.push_back('{typed, r});
    in_valid_i <= 1'b1;
    accel_x_i <= f.ax;
    accel_y_i <= f.ay;
    accel_z_i <= f.az;
    echo_width_us_i <= f.echo;
    temp_raw_i <= f.temp;
    time_ms_i <= f.ms;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (expected_results.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) begin
      f.ax = 16'($signed($urandom_range(0, 8192)) - 4096);
      f.ay = 16'($signed($urandom_range(0, 8192)) - 4096);
      f.az = 16'($signed($urandom_range(0, 8192)) - 4096);
    end else if (k < 80) begin
      f.ax = 16'($signed($urandom_range(0, 40000)) - 20000);
      f.ay = 16'($signed($urandom_range(0, 40000)) - 20000);
      f.az = 16'($signed($urandom_range(0, 40000)) - 20000);
    end else begin
      f.ax = 16'($urandom());
      f.ay = 16'($urandom());
      f.az = 16'($urandom());
    end
    if ($urandom_range(0, 19) == 0) f.ay = '0;
    k = $urandom_range(0, 99);
    if (k < 70) f.echo = 15'($urandom_range(1, 3700));
    else if (k < 80) f.echo = '0;
    else f.echo = 15'($urandom());
    f.temp = 13'($urandom());
    if ($urandom_range(0, 49) == 0) now_ms = $urandom();
    else now_ms = now_ms + $urandom_range(0, 400);
    f.ms = now_ms;
    return f;
  endfunction

  initial begin
    dir_row_t table_rows[$];
    result_t quiet, none;
    logic [31:0] phases[8][7];
    quiet = '{13'sd0, 12'sd0, 13'd0, 1'b0, 13'sd400, 1'b0};
    none = '{13'sd0, 12'sd0, 13'd0, 1'b0, 13'sd0, 1'b0};

    rst_ni <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid_i <= 1'b0;
    accel_x_i <= '0; accel_y_i <= '0; accel_z_i <= '0;
    echo_width_us_i <= '0; temp_raw_i <= '0; time_ms_i <= '0;
    weight_m = 9'd77; threshold_m = 16'd3341; gravity_m = 16'd4097; cooldown_m = 16'd350;
    dist_limit_m = 13'd960; motion_en_m = 1'b1; temp_en_m = 1'b1;
    roll_s = 0; pitch_s = 0; dist_s = 0; hand_s = 1'b0; temp_s = 400; last_shake_s = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // zero frames right after reset; y zero with z negative gives +180 roll
    table_rows = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 15'd0, 13'sd400, 32'd0}, 1'b1, quiet},
      '{'{16'sd0, 16'sd0, 16'sd0, 15'd0, 13'sd400, 32'd100}, 1'b1, quiet},
      '{'{16'sd0, 16'sd0, 16'sd4096, 15'd580, 13'sd400, 32'd200}, 1'b0, none},
      '{'{16'sd0, 16'sd0, -16'sd4096, 15'd600, 13'sd320, 32'd300}, 1'b0, none},
      '{'{16'sd0, 16'sd4096, 16'sd0, 15'd620, 13'sd100, 32'd400}, 1'b0, none},
      '{'{16'sd0, -16'sd1, -16'sd4096, 15'd3480, 13'sd0, 32'd500}, 1'b0, none},
      '{'{16'sd4096, 16'sd0, 16'sd0, 15'd3481, 13'sd0, 32'd600}, 1'b0, none},
      '{'{-16'sd4096, 16'sd0, 16'sd0, 15'd3483, 13'sd0, 32'd700}, 1'b0, none},
      '{'{-16'sd32768, -16'sd32768, -16'sd32768, 15'd32767, -13'sd4096, 32'd1000},
        1'b0, none},
      '{'{16'sd32767, 16'sd32767, 16'sd32767, 15'd1, 13'sd4095, 32'd1100}, 1'b0, none},
      '{'{16'sd20000, 16'sd0, 16'sd0, 15'd2, 13'sd4095, 32'd1500}, 1'b0, none},
      '{'{16'sd0, 16'sd0, 16'sd0, 15'd3000, -13'sd4096, 32'hFFFF_FF00}, 1'b0, none},
      '{'{16'sd0, 16'sd0, 16'sd0, 15'd3000, -13'sd4096, 32'd5}, 1'b0, none},
      '{'{16'sd0, 16'sd0, 16'sd0, 15'd0, 13'sd1, 32'd600}, 1'b0, none},
      '{'{-16'sd32768, 16'sd0, -16'sd1, 15'd1000, 13'sd2, 32'd2000}, 1'b0, none},
      '{'{16'sd1, 16'sd1, 16'sd1, 15'd16384, 13'sd3, 32'h8000_0000}, 1'b0, none}
    };
    foreach (table_rows[i]) begin
      send_frame(table_rows[i].f, table_rows[i].typed, table_rows[i].r);
      idle_gap();
    end
    drain();

    phases = '{
      '{32'd256, 32'd3341, 32'd4097, 32'd350, 32'd960, 32'd1, 32'd1},
      '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1},
      '{32'd511, 32'd65535, 32'd65535, 32'd65535, 32'd8191, 32'd1, 32'd1},
      '{32'd128, 32'd1000, 32'd4096, 32'd50, 32'd8191, 32'd0, 32'd1},
      '{32'd200, 32'd2000, 32'd4096, 32'd0, 32'd2000, 32'd1, 32'd0},
      '{32'd1, 32'd500, 32'd4096, 32'd65535, 32'd500, 32'd0, 32'd0},
      '{32'd77, 32'd3341, 32'd4097, 32'd350, 32'd960, 32'd1, 32'd1},
      '{$urandom_range(0, 511), $urandom_range(0, 8000), $urandom_range(0, 9000),
        $urandom_range(0, 1000), $urandom_range(0, 8191), 32'd1, 32'd1}
    };
    foreach (phases[p]) begin
      write_reg(RegWeight, phases[p][0], 9);
      write_reg(RegThreshold, phases[p][1], 16);
      write_reg(RegGravity, phases[p][2], 16);
      write_reg(RegCooldown, phases[p][3], 16);
      write_reg(RegDistLimit, phases[p][4], 13);
      write_reg(RegMotionEn, phases[p][5], 1);
      write_reg(RegTempEn, phases[p][6], 1);
      @(posedge clk_i);
      // receiver backs off so the block fills up and stalls its input
      if (p == 2) hold_output = 1'b1;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        send_frame(random_frame(), 1'b0, none);
        if (p == 4 && i == ItemsPerPhase / 2) drain();
        else idle_gap();
      end
      drain();
    end

    if (mismatch_count == 0 && typed_notes.size() == 0) begin
      $display("tb_motion_frame_conditioner_top: clean");
    end else begin
      $display("tb_motion_frame_conditioner_top: errors");
    end
    $finish;
  end

endmodule
